// File: hdl/neighborhood_window_generator_defines.svh
// Assertion macros for the window generator
`ifndef NEIGHBORHOOD_WINDOW_GENERATOR_DEFINES_SVH
`define NEIGHBORHOOD_WINDOW_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define NWG_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("window generator check failed");
`define NWG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("window generator check failed");
`else
`define NWG_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define NWG_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: hdl/nwg_pkg.sv
package nwg_pkg;

    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned MAX_HEIGHT  = 1024;
    localparam int unsigned HIST_DEPTH  = 2 * MAX_WIDTH + 2;
    localparam int unsigned SLOT_W      = $clog2(HIST_DEPTH);
    localparam int unsigned WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HGT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned CFG_ADDR_W  = 1;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned IDX_W       = 20;
    localparam int unsigned WIN_SIZE    = 9;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned OUT_DEPTH   = 4;
    localparam int unsigned OPTR_W      = $clog2(OUT_DEPTH);
    localparam int unsigned OCNT_W      = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET      = CFG_DATA_W'(640);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET     = CFG_DATA_W'(480);

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] up_left;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] up_right;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] down_left;
        logic [PIX_W-1:0] down;
        logic [PIX_W-1:0] down_right;
        logic [IDX_W-1:0] center_index;
        logic             last_of_image;
    } out_item_t;

    typedef struct packed {
        logic              write;
        logic              emit;
        logic              last;
        logic              ovr;
        logic [SLOT_W-1:0] wr_slot;
        logic [PIX_W-1:0]  pix;
        logic [CNT_W-1:0]  center_pos;
        logic [SLOT_W-1:0] center_slot;
    } op_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [CNT_W-1:0] count;
    } cfg_t;

endpackage

// File: hdl/nwg_ram.sv
module nwg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/nwg_front.sv
module nwg_front
    import nwg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  queue_full,
    output logic                  op_push,
    output op_t                   op,
    output cfg_t                  cfg
);

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        int unsigned x;
        x = 32'(v);
        if (x == 0)
        begin
            x = 1;
        end
        else if (x > hi)
        begin
            x = hi;
        end
        return x;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(HIST_DEPTH - 1))
        begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  cfg_wait_reg;
    logic [WID_W-1:0]      width_eff_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [WID_W-1:0]      width_eff_next;
    logic [HGT_W-1:0]      height_eff_next;
    logic [CNT_W-1:0]      count_next;

    logic [CNT_W-1:0]  rx_reg, rx_next;
    logic [CNT_W-1:0]  tx_reg, tx_next;
    logic [SLOT_W-1:0] rx_slot_reg, rx_slot_next;
    logic [SLOT_W-1:0] tx_slot_reg, tx_slot_next;

    logic             accept;
    logic             is_pixel;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] w_span;
    logic             pix_ok;
    logic             room;
    logic             flush_ok;
    logic             flush_clear;
    logic             emit;
    logic             at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            cfg_wait_reg <= 1'b1;
        end
        else
        begin
            cfg_wait_reg <= cfg_write_en;
            if (cfg_write_en)
            begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        width_eff_next  = WID_W'(clamp_dim(width_reg, MAX_WIDTH));
        height_eff_next = HGT_W'(clamp_dim(height_reg, MAX_HEIGHT));
        count_next      = CNT_W'(width_eff_next) * CNT_W'(height_eff_next);
    end

    always_ff @(posedge clk)
    begin
        width_eff_reg <= width_eff_next;
        count_reg     <= count_next;
    end

    always_comb
    begin
        accept      = in_valid && in_ready;
        is_pixel    = (in_data.action == ACTION_PIXEL);
        span        = rx_reg - tx_reg;
        w_span      = CNT_W'(width_eff_reg) + CNT_W'(1);
        pix_ok      = is_pixel && (rx_reg < count_reg);
        room        = (tx_reg < rx_reg) && (span >= w_span);
        flush_ok    = !is_pixel && (rx_reg >= count_reg);
        flush_clear = flush_ok && (tx_reg >= count_reg);
        emit        = (pix_ok && room) || (flush_ok && !flush_clear);
        at_end      = (tx_reg + CNT_W'(1)) >= count_reg;

        op.write       = pix_ok;
        op.emit        = emit;
        op.last        = emit && at_end;
        op.ovr         = pix_ok && (span == w_span);
        op.wr_slot     = rx_slot_reg;
        op.pix         = in_data.pixel_value;
        op.center_pos  = tx_reg;
        op.center_slot = tx_slot_reg;
        op_push        = accept && (pix_ok || emit);

        rx_next      = rx_reg;
        tx_next      = tx_reg;
        rx_slot_next = rx_slot_reg;
        tx_slot_next = tx_slot_reg;
        if (accept)
        begin
            if ((emit && at_end) || flush_clear)
            begin
                rx_next      = '0;
                tx_next      = '0;
                rx_slot_next = '0;
                tx_slot_next = '0;
            end
            else
            begin
                if (emit)
                begin
                    tx_next      = tx_reg + CNT_W'(1);
                    tx_slot_next = slot_inc(tx_slot_reg);
                end
                if (pix_ok)
                begin
                    rx_next      = rx_reg + CNT_W'(1);
                    rx_slot_next = slot_inc(rx_slot_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg      <= '0;
            tx_reg      <= '0;
            rx_slot_reg <= '0;
            tx_slot_reg <= '0;
        end
        else
        begin
            rx_reg      <= rx_next;
            tx_reg      <= tx_next;
            rx_slot_reg <= rx_slot_next;
            tx_slot_reg <= tx_slot_next;
        end
    end

    assign in_ready  = !cfg_wait_reg && !queue_full;
    assign cfg.width = width_eff_reg;
    assign cfg.count = count_reg;

endmodule

// File: hdl/nwg_op_queue.sv
module nwg_op_queue
    import nwg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op,
    output logic full
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

// File: hdl/nwg_back.sv
module nwg_back
    import nwg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  op_t       head_op,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [SLOT_W:0]   tap_off  [WIN_SIZE];
    logic [SLOT_W:0]   tap_sum  [WIN_SIZE];
    logic [SLOT_W-1:0] tap_slot [WIN_SIZE];
    logic [PIX_W-1:0]  tap_data [WIN_SIZE];
    logic [PIX_W-1:0]  win      [WIN_SIZE];
    logic [WIN_SIZE-1:0] tap_ok;

    logic [SLOT_W:0]  w_s;
    logic [SLOT_W:0]  depth_s;
    logic [CNT_W:0]   pos_e;
    logic [CNT_W:0]   w_e;
    logic [CNT_W:0]   n_e;
    logic [CNT_W:0]   one_e;
    logic             hist_wr;
    logic             has_room;
    out_item_t        result;

    logic                s1_emit_reg;
    logic [WIN_SIZE-1:0] s1_ok_reg;
    logic                s1_ovr_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [IDX_W-1:0]    s1_pos_reg;
    logic                s1_last_reg;

    out_item_t         ob_entry_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] ob_wr_ptr_reg, ob_wr_ptr_next;
    logic [OPTR_W-1:0] ob_rd_ptr_reg, ob_rd_ptr_next;
    logic [OCNT_W-1:0] ob_count_reg, ob_count_next;
    logic              ob_push;
    logic              ob_pop;

    // hold emitting ops until the result buffer has a free place for them
    assign has_room = ({1'b0, ob_count_reg} + (OCNT_W + 1)'(s1_emit_reg))
                      < (OCNT_W + 1)'(OUT_DEPTH);
    assign pop      = head_valid && (!head_op.emit || has_room);
    assign hist_wr  = pop && head_op.write;

    always_comb
    begin
        w_s     = (SLOT_W + 1)'(cfg.width);
        depth_s = (SLOT_W + 1)'(HIST_DEPTH);

        tap_off[0] = depth_s - w_s - (SLOT_W + 1)'(1);
        tap_off[1] = depth_s - w_s;
        tap_off[2] = depth_s - w_s + (SLOT_W + 1)'(1);
        tap_off[3] = depth_s - (SLOT_W + 1)'(1);
        tap_off[4] = '0;
        tap_off[5] = (SLOT_W + 1)'(1);
        tap_off[6] = w_s - (SLOT_W + 1)'(1);
        tap_off[7] = w_s;
        tap_off[8] = w_s + (SLOT_W + 1)'(1);

        for (int k = 0; k < WIN_SIZE; k++)
        begin
            tap_sum[k]  = (SLOT_W + 1)'(head_op.center_slot) + tap_off[k];
            tap_slot[k] = (tap_sum[k] >= depth_s) ? SLOT_W'(tap_sum[k] - depth_s)
                                                  : SLOT_W'(tap_sum[k]);
        end

        pos_e = (CNT_W + 1)'(head_op.center_pos);
        w_e   = (CNT_W + 1)'(cfg.width);
        n_e   = (CNT_W + 1)'(cfg.count);
        one_e = (CNT_W + 1)'(1);

        tap_ok[0] = pos_e >= (w_e + one_e);
        tap_ok[1] = pos_e >= w_e;
        tap_ok[2] = (pos_e + one_e) >= w_e;
        tap_ok[3] = pos_e != '0;
        tap_ok[4] = 1'b1;
        tap_ok[5] = (pos_e + one_e) < n_e;
        tap_ok[6] = (pos_e + w_e - one_e) < n_e;
        tap_ok[7] = (pos_e + w_e) < n_e;
        tap_ok[8] = (pos_e + w_e + one_e) < n_e;
    end

    for (genvar k = 0; k < WIN_SIZE; k++)
    begin : g_hist
        nwg_ram #(
            .WIDTH (PIX_W),
            .DEPTH (HIST_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (hist_wr),
            .wr_addr (head_op.wr_slot),
            .wr_data (head_op.pix),
            .rd_addr (tap_slot[k]),
            .rd_data (tap_data[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_emit_reg <= 1'b0;
        end
        else
        begin
            s1_emit_reg <= pop && head_op.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ok_reg   <= tap_ok;
            s1_ovr_reg  <= head_op.ovr;
            s1_pix_reg  <= head_op.pix;
            s1_pos_reg  <= IDX_W'(head_op.center_pos);
            s1_last_reg <= head_op.last;
        end
    end

    // replace out-of-image taps by the center, take the incoming pixel unstored
    always_comb
    begin
        for (int k = 0; k < WIN_SIZE; k++)
        begin
            win[k] = s1_ok_reg[k] ? tap_data[k] : tap_data[4];
        end
        if (s1_ovr_reg)
        begin
            win[8] = s1_pix_reg;
        end

        result.up_left       = win[0];
        result.up            = win[1];
        result.up_right      = win[2];
        result.left          = win[3];
        result.center        = win[4];
        result.right         = win[5];
        result.down_left     = win[6];
        result.down          = win[7];
        result.down_right    = win[8];
        result.center_index  = s1_pos_reg;
        result.last_of_image = s1_last_reg;
    end

    assign ob_push = s1_emit_reg;
    assign ob_pop  = out_valid && out_ready;

    always_comb
    begin
        ob_wr_ptr_next = ob_wr_ptr_reg;
        ob_rd_ptr_next = ob_rd_ptr_reg;
        ob_count_next  = ob_count_reg;
        if (ob_push)
        begin
            ob_wr_ptr_next = (ob_wr_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                      : ob_wr_ptr_reg + OPTR_W'(1);
        end
        if (ob_pop)
        begin
            ob_rd_ptr_next = (ob_rd_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                      : ob_rd_ptr_reg + OPTR_W'(1);
        end
        if (ob_push && !ob_pop)
        begin
            ob_count_next = ob_count_reg + OCNT_W'(1);
        end
        else if (ob_pop && !ob_push)
        begin
            ob_count_next = ob_count_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_count_reg  <= '0;
        end
        else
        begin
            ob_wr_ptr_reg <= ob_wr_ptr_next;
            ob_rd_ptr_reg <= ob_rd_ptr_next;
            ob_count_reg  <= ob_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_entry_reg[ob_wr_ptr_reg] <= result;
        end
    end

    assign out_valid = (ob_count_reg != '0);
    assign out_data  = ob_entry_reg[ob_rd_ptr_reg];

endmodule

// File: hdl/neighborhood_window_generator.sv
// 3x3 neighborhood window generator. Takes one transfer per clock, pixel or flush, and
// can give one window per clock; input transfers keep flowing while a finished window
// waits at the output, until the four-entry op queue and the four-entry result buffer
// fill. A window goes from the transfer that completes it through the op queue, the
// registered history read and the result buffer. The pixel history of 2*MAX_WIDTH+2
// bytes sits in nine RAM copies that take every pixel write, so each copy returns one
// neighbor per clock; that single read port per copy is what sets the rate of one window
// per cycle. The history needs no clearing after reset. After a register write the input
// drops ready in the next cycle while the clamped width and pixel count are registered.
`include "neighborhood_window_generator_defines.svh"

module neighborhood_window_generator
    import nwg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    cfg_t cfg;
    op_t  op;
    op_t  head_op;
    logic op_push;
    logic queue_full;
    logic head_valid;
    logic queue_pop;

    nwg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .queue_full   (queue_full),
        .op_push      (op_push),
        .op           (op),
        .cfg          (cfg)
    );

    nwg_op_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (op_push),
        .push_op    (op),
        .pop        (queue_pop),
        .head_valid (head_valid),
        .head_op    (head_op),
        .full       (queue_full)
    );

    nwg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    `NWG_ASSERT_NEXT(a_cfg_write_holds_input, clk, rst_n, cfg_write_en, !in_ready)
    `NWG_ASSERT_NOW(a_push_not_full, clk, rst_n, op_push, !queue_full)
    `NWG_ASSERT_NOW(a_pop_not_empty, clk, rst_n, queue_pop, head_valid)

endmodule
